[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with an active-low reset as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

[rtl/core/mbet_pkg.sv]
// ----------------------------------------------------------------------------
// mbet_pkg
// Payload types, register indexes and reset values of the escape-time unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

    localparam int COORD_W    = 32;
    localparam int ITER_W     = 12;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP = 2'd2;

    localparam logic [ITER_W-1:0]  MAX_ITER_RST   = 12'd150;
    localparam logic [COLOR_W-1:0] COLOR_BASE_RST = 24'd0;
    localparam logic [COLOR_W-1:0] COLOR_STEP_RST = 24'd111411;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               escaped;
        logic [ITER_W-1:0]  iterations;
    } t_out_item;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

endpackage

`default_nettype wire

[rtl/core/mandelbrot_escape_time.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Iterates z = z*z + c in signed fixed point on one shared multiplier and
// reports the escape step and colour of each point.
// ----------------------------------------------------------------------------
// Channel  Role    Signals
// in       sink    i_in_valid, o_in_ready, i_in_data
// out      source  o_out_valid, i_out_ready, o_out_data
// cfg      sink    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// One step forms three products for the update and two for the escape check,
// each over ND*ND digit pairs, where ND is the number of multiplier digits
// per operand (ND = 1 up to FRAC_BITS of 29); the single digit multiplier
// sets how long a point takes from its transfer to its result.
// The input is ready only while no point is in flight.
// Reset is synchronous and returns the control and configuration registers to their default values.
// A result waits in the output register while the next point is computed.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time #(
    parameter int FRAC_BITS = 28
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  mbet_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output mbet_pkg::t_out_item  o_out_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  mbet_pkg::t_cfg_idx   i_cfg_index,
    input  mbet_pkg::t_cfg_data  i_cfg_data
);

    import mbet_pkg::*;

    localparam int MW   = FRAC_BITS + 3;
    localparam int ZMW  = FRAC_BITS + 2;
    localparam int ND   = (MW + 31) / 32;
    localparam int DW   = (MW + ND - 1) / ND;
    localparam int PADW = ND * DW;
    localparam int PW   = 2 * PADW;
    localparam int CW   = (ND > 1) ? $clog2(ND) : 1;
    localparam int TW   = ((FRAC_BITS + 5 > COORD_W) ? FRAC_BITS + 5 : COORD_W) + 1;
    localparam int RE2W = FRAC_BITS + 3;
    localparam int XYW  = FRAC_BITS + 4;
    localparam int SQW  = FRAC_BITS + 5;
    localparam int MAGW = FRAC_BITS + 6;

    localparam logic [CW-1:0]   DIG_LAST   = CW'(ND - 1);
    localparam logic [MAGW-1:0] ESC_LIMIT  = MAGW'(4) << FRAC_BITS;
    localparam logic [TW-1:0]   CLAMP_T    = TW'(1) << (FRAC_BITS + 2);
    localparam logic [MW-1:0]   CLAMP_M    = MW'(1) << (FRAC_BITS + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_MAG   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [2:0] K_RR = 3'd0;
    localparam logic [2:0] K_II = 3'd1;
    localparam logic [2:0] K_RI = 3'd2;
    localparam logic [2:0] K_XX = 3'd3;
    localparam logic [2:0] K_YY = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [2:0]                r_k, n_k;
    logic [CW-1:0]             r_di, n_di;
    logic [CW-1:0]             r_dj, n_dj;
    logic [PW-1:0]             r_acc, n_acc;
    logic [ZMW-1:0]            r_zr_mag, n_zr_mag;
    logic [ZMW-1:0]            r_zi_mag, n_zi_mag;
    logic                      r_zr_neg, n_zr_neg;
    logic                      r_zi_neg, n_zi_neg;
    logic signed [COORD_W-1:0] r_c_re, n_c_re;
    logic signed [COORD_W-1:0] r_c_im, n_c_im;
    logic [RE2W-1:0]           r_re2, n_re2;
    logic [RE2W-1:0]           r_im2, n_im2;
    logic [XYW-1:0]            r_xy, n_xy;
    logic signed [TW-1:0]      r_tx, n_tx;
    logic signed [TW-1:0]      r_ty, n_ty;
    logic [MW-1:0]             r_ax, n_ax;
    logic [MW-1:0]             r_ay, n_ay;
    logic [SQW-1:0]            r_sqx, n_sqx;
    logic [SQW-1:0]            r_sqy, n_sqy;
    logic [ITER_W-1:0]         r_iter, n_iter;
    logic [COLOR_W-1:0]        r_col, n_col;
    t_out_item                 r_res, n_res;
    t_out_item                 r_out, n_out;
    logic                      r_out_valid, n_out_valid;
    logic [ITER_W-1:0]         r_max_iter, n_max_iter;
    logic [COLOR_W-1:0]        r_color_base, n_color_base;
    logic [COLOR_W-1:0]        r_color_step, n_color_step;

    logic [MW-1:0]        op_a, op_b;
    logic [PADW-1:0]      op_a_pad, op_b_pad;
    logic [DW-1:0]        dig_a, dig_b;
    logic [2*DW-1:0]      pp;
    logic [PW-1:0]        pp_sh;
    logic [PW-1:0]        acc_sum;
    logic                 last_dig;
    logic signed [TW-1:0] re2_s, im2_s, xy_s, c_re_s, c_im_s;
    logic signed [TW-1:0] tx_calc, ty_calc;
    logic [TW-1:0]        ax_abs, ay_abs;
    logic [MW-1:0]        ax_clamp, ay_clamp;
    logic [MAGW-1:0]      mag_sum;
    logic                 escape;
    logic                 last_step;

    // Operand select for the shared multiplier; all operands are magnitudes.
    always_comb begin
        case (r_k)
            K_RR: begin
                op_a = MW'(r_zr_mag);
                op_b = MW'(r_zr_mag);
            end
            K_II: begin
                op_a = MW'(r_zi_mag);
                op_b = MW'(r_zi_mag);
            end
            K_RI: begin
                op_a = {r_zr_mag, 1'b0};
                op_b = MW'(r_zi_mag);
            end
            K_XX: begin
                op_a = r_ax;
                op_b = r_ax;
            end
            K_YY: begin
                op_a = r_ay;
                op_b = r_ay;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign op_a_pad = PADW'(op_a);
    assign op_b_pad = PADW'(op_b);
    assign dig_a    = op_a_pad[r_di*DW +: DW];
    assign dig_b    = op_b_pad[r_dj*DW +: DW];
    assign pp       = dig_a * dig_b;
    assign pp_sh    = PW'(pp) << (DW * (int'(r_di) + int'(r_dj)));
    assign acc_sum  = r_acc + pp_sh;
    assign last_dig = (r_di == DIG_LAST) && (r_dj == DIG_LAST);

    assign re2_s   = signed'(TW'(r_re2));
    assign im2_s   = signed'(TW'(r_im2));
    assign xy_s    = signed'(TW'(r_xy));
    assign c_re_s  = TW'(r_c_re);
    assign c_im_s  = TW'(r_c_im);
    assign tx_calc = re2_s - im2_s + c_re_s;
    assign ty_calc = ((r_zr_neg ^ r_zi_neg) ? -xy_s : xy_s) + c_im_s;

    // A magnitude of four or more escapes for sure, so it is clamped there.
    assign ax_abs   = r_tx[TW-1] ? TW'(-r_tx) : TW'(r_tx);
    assign ay_abs   = r_ty[TW-1] ? TW'(-r_ty) : TW'(r_ty);
    assign ax_clamp = (ax_abs >= CLAMP_T) ? CLAMP_M : ax_abs[MW-1:0];
    assign ay_clamp = (ay_abs >= CLAMP_T) ? CLAMP_M : ay_abs[MW-1:0];

    assign mag_sum   = MAGW'(r_sqx) + MAGW'(r_sqy);
    assign escape    = mag_sum > ESC_LIMIT;
    assign last_step = (r_iter + ITER_W'(1)) == r_max_iter;

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_di         = r_di;
        n_dj         = r_dj;
        n_acc        = r_acc;
        n_zr_mag     = r_zr_mag;
        n_zi_mag     = r_zi_mag;
        n_zr_neg     = r_zr_neg;
        n_zi_neg     = r_zi_neg;
        n_c_re       = r_c_re;
        n_c_im       = r_c_im;
        n_re2        = r_re2;
        n_im2        = r_im2;
        n_xy         = r_xy;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_ax         = r_ax;
        n_ay         = r_ay;
        n_sqx        = r_sqx;
        n_sqy        = r_sqy;
        n_iter       = r_iter;
        n_col        = r_col;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_max_iter   = r_max_iter;
        n_color_base = r_color_base;
        n_color_step = r_color_step;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAX_ITER:   n_max_iter   = i_cfg_data[ITER_W-1:0];
                REG_COLOR_BASE: n_color_base = i_cfg_data[COLOR_W-1:0];
                REG_COLOR_STEP: n_color_step = i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_c_re   = i_in_data.c_re;
                    n_c_im   = i_in_data.c_im;
                    n_zr_mag = '0;
                    n_zi_mag = '0;
                    n_zr_neg = 1'b0;
                    n_zi_neg = 1'b0;
                    n_iter   = '0;
                    n_col    = r_color_base;
                    n_k      = K_RR;
                    n_di     = '0;
                    n_dj     = '0;
                    n_acc    = '0;
                    if (r_max_iter == '0) begin
                        n_res   = '{color: '0, escaped: 1'b0, iterations: '0};
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_acc = acc_sum;
                if (last_dig) begin
                    n_acc = '0;
                    n_di  = '0;
                    n_dj  = '0;
                    case (r_k)
                        K_RR: begin
                            n_re2 = acc_sum[FRAC_BITS +: RE2W];
                            n_k   = K_II;
                        end
                        K_II: begin
                            n_im2 = acc_sum[FRAC_BITS +: RE2W];
                            n_k   = K_RI;
                        end
                        K_RI: begin
                            n_xy    = acc_sum[FRAC_BITS +: XYW];
                            n_state = S_CALC;
                        end
                        K_XX: begin
                            n_sqx = acc_sum[FRAC_BITS +: SQW];
                            n_k   = K_YY;
                        end
                        K_YY: begin
                            n_sqy   = acc_sum[FRAC_BITS +: SQW];
                            n_state = S_CHECK;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end else if (r_dj == DIG_LAST) begin
                    n_dj = '0;
                    n_di = r_di + CW'(1);
                end else begin
                    n_dj = r_dj + CW'(1);
                end
            end
            S_CALC: begin
                n_tx    = tx_calc;
                n_ty    = ty_calc;
                n_state = S_MAG;
            end
            S_MAG: begin
                n_ax    = ax_clamp;
                n_ay    = ay_clamp;
                n_k     = K_XX;
                n_state = S_MUL;
            end
            S_CHECK: begin
                if (escape) begin
                    n_res   = '{color: r_col, escaped: 1'b1, iterations: r_iter};
                    n_state = S_FIN;
                end else if (last_step) begin
                    n_res   = '{color: '0, escaped: 1'b0, iterations: r_max_iter};
                    n_state = S_FIN;
                end else begin
                    // A point that stays has both parts within two, so no clamp applied.
                    n_zr_mag = r_ax[ZMW-1:0];
                    n_zi_mag = r_ay[ZMW-1:0];
                    n_zr_neg = r_tx[TW-1];
                    n_zi_neg = r_ty[TW-1];
                    n_iter   = r_iter + ITER_W'(1);
                    n_col    = r_col + r_color_step;
                    n_k      = K_RR;
                    n_state  = S_MUL;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= K_RR;
            r_di         <= '0;
            r_dj         <= '0;
            r_out_valid  <= 1'b0;
            r_max_iter   <= MAX_ITER_RST;
            r_color_base <= COLOR_BASE_RST;
            r_color_step <= COLOR_STEP_RST;
        end else begin
            r_state      <= n_state;
            r_k          <= n_k;
            r_di         <= n_di;
            r_dj         <= n_dj;
            r_out_valid  <= n_out_valid;
            r_max_iter   <= n_max_iter;
            r_color_base <= n_color_base;
            r_color_step <= n_color_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_zr_mag <= n_zr_mag;
        r_zi_mag <= n_zi_mag;
        r_zr_neg <= n_zr_neg;
        r_zi_neg <= n_zi_neg;
        r_c_re   <= n_c_re;
        r_c_im   <= n_c_im;
        r_re2    <= n_re2;
        r_im2    <= n_im2;
        r_xy     <= n_xy;
        r_tx     <= n_tx;
        r_ty     <= n_ty;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_sqx    <= n_sqx;
        r_sqy    <= n_sqy;
        r_iter   <= n_iter;
        r_col    <= n_col;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[rtl/core/mbet_checker.sv]
// ----------------------------------------------------------------------------
// mbet_checker
// Port-level checks of the escape-time unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mbet_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input mbet_pkg::t_out_item  o_out_data,
    input wire                  i_cfg_valid,
    input wire                  o_cfg_ready,
    input mbet_pkg::t_cfg_idx   i_cfg_index,
    input mbet_pkg::t_cfg_data  i_cfg_data
);

    import mbet_pkg::*;

    logic [ITER_W-1:0] r_max_iter;

    // Shadow copy of the iteration limit, taken from configuration transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_MAX_ITER)) begin
            r_max_iter <= i_cfg_data[ITER_W-1:0];
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMPL(a_esc_iter, i_clk, i_rst_n, o_out_valid && o_out_data.escaped, o_out_data.iterations < r_max_iter)
    `ASSERT_IMPL(a_inside, i_clk, i_rst_n, o_out_valid && !o_out_data.escaped, (o_out_data.iterations == r_max_iter) && (o_out_data.color == '0))

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire
